/* design/slid_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted list package
// Shared sizes, status codes and controller command type for the sorted list.
// ----------------------------------------------------------------------------
package slid_pkg;

  // Number of keys the list can hold.
  localparam int CAPACITY = 16;
  // Width of the internal entry counter, wide enough to hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int KEY_W = 8;
  localparam int COUNT_W = 5;
  localparam int STATUS_W = 2;

  // Operation codes carried on the mode field.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DELETED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the operation of the accepted beat
    logic exec;  // update the list and load the result register
  } slid_cmd_t;

endpackage

/* design/slid_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted list controller
// Sequences one operation at a time and tracks the result register.
// ----------------------------------------------------------------------------
module slid_ctrl
  import slid_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output slid_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;

  // The result register can take a new result when empty or emptied this cycle.
  assign slot_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);
  assign cmd.load = (state == S_IDLE) && in_valid;
  assign cmd.exec = (state == S_EXEC) && slot_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.exec) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* design/slid_datapath.sv */
// ----------------------------------------------------------------------------
// Sorted list datapath
// A row of key cells, each comparing its key and shifting from a neighbor.
// ----------------------------------------------------------------------------
module slid_datapath
  import slid_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  slid_cmd_t                  cmd,
  input  logic                       mode,
  input  logic signed [KEY_W-1:0]    key,
  output logic        [STATUS_W-1:0] status,
  output logic        [COUNT_W-1:0]  count
);

  // Operand registers.
  logic                    op_mode;
  logic signed [KEY_W-1:0] op_key;

  // List cells and fill count.
  logic signed [KEY_W-1:0] cells [CAPACITY];
  logic signed [KEY_W-1:0] cells_next [CAPACITY];
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        cnt_next;
  logic [STATUS_W-1:0]     status_next;

  // Per-cell flags.
  logic [CAPACITY-1:0] live;
  logic [CAPACITY-1:0] greater;
  logic [CAPACITY-1:0] equal;
  logic [CAPACITY-1:0] hit;
  logic                found;
  logic                full;

  assign full = (cnt == CNT_W'(CAPACITY));
  assign found = |equal;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      live[i] = (CNT_W'(i) < cnt);
      greater[i] = live[i] && (op_key > cells[i]);
      equal[i] = live[i] && (cells[i] == op_key);
    end
    // A cell shifts on delete when it or any lower cell holds the first match.
    for (int i = 0; i < CAPACITY; i++) begin
      hit[i] = |(equal & ((CAPACITY)'(1) << i | (((CAPACITY)'(1) << i) - (CAPACITY)'(1))));
    end
  end

  always_comb begin
    cells_next = cells;
    cnt_next = cnt;
    status_next = ST_INSERTED;
    if (op_mode == OP_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_INSERTED;
        cnt_next = cnt + CNT_W'(1);
        for (int i = 0; i < CAPACITY; i++) begin
          if (!greater[i]) begin
            if (i == 0) begin
              cells_next[i] = op_key;
            end else if (greater[i-1]) begin
              cells_next[i] = op_key;
            end else begin
              cells_next[i] = cells[i-1];
            end
          end
        end
      end
    end else begin
      if (!found) begin
        status_next = ST_NOT_FOUND;
      end else begin
        status_next = ST_DELETED;
        cnt_next = cnt - CNT_W'(1);
        for (int i = 0; i < CAPACITY; i++) begin
          if (hit[i]) begin
            if (i == CAPACITY - 1) begin
              cells_next[i] = '0;
            end else begin
              cells_next[i] = cells[i+1];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode <= mode;
      op_key <= key;
    end
    if (cmd.exec) begin
      cells <= cells_next;
      status <= status_next;
      count <= COUNT_W'(cnt_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.exec) begin
      cnt <= cnt_next;
    end
  end

endmodule

/* design/sorted_list_insert_delete.sv */
// ----------------------------------------------------------------------------
// Sorted list with insert and delete
// Bounded ascending list of signed 8-bit keys with one result per operation.
// ----------------------------------------------------------------------------
// The block keeps up to 16 signed 8-bit keys in ascending order, duplicates
// allowed. Each input beat carries a mode (insert or delete) and a key. An
// insert places the key ahead of the first stored key that is not smaller;
// on a full list the key is dropped and the status reports full. A delete
// removes the lowest stored key equal to the given one, or reports not found.
// Every input beat yields exactly one output beat with a status and the
// number of keys held afterward. One operation is in flight at a time: the
// input beat is captured into the operand registers, and then the row of
// compare-and-shift cells updates the whole list once the result register
// has room. The result sits in an output register, so the next input beat
// is taken while an earlier result still waits there; an item whose result
// finds that register still occupied waits until it drains.
// After reset the list is empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete
  import slid_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       mode,
  input  logic signed [KEY_W-1:0]    key,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic        [STATUS_W-1:0] status,
  output logic        [COUNT_W-1:0]  count
);

  slid_cmd_t cmd;

  // Controller: accepts a beat, then fires one execute when the result
  // register has room.
  slid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Datapath: operand registers, the key cells, the fill count and the
  // result register.
  slid_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .mode   (mode),
    .key    (key),
    .status (status),
    .count  (count)
  );

`ifndef SYNTH
  // Once a beat is taken, no further beat is taken until it has executed.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an operation was pending");

  // A full result only appears when the list holds its whole capacity.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (count == COUNT_W'(CAPACITY)))
    else $error("full status with a list that is not full");

  // The fill count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    u_dp.cnt <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // An execute is only issued when the result register can take it.
  a_exec_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> (!out_valid || !out_stall))
    else $error("result overwritten before it was taken");
`endif

endmodule

/* verif/tb_sorted_list_insert_delete.sv */
// ----------------------------------------------------------------------------
// Sorted list insert/delete testbench
// Drives insert and delete beats through the valid/stall input channel and
// checks every output beat against a local model of the ascending key list.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sorted_list_insert_delete;
  import slid_pkg::*;

  // Number of random beats after the directed table.
  localparam int RANDOM_OPS = 550;
  // Hard stop. The slowest correct run is about 600 beats with sender gaps and
  // receiver stalls, so this limit is many times over.
  localparam int CYCLE_LIMIT = 200000;
  // Cycles to keep watching after the last expected result.
  localparam int DRAIN_CYCLES = 10;
  localparam int PRINT_CAP = 40;

  // One result beat: status and the number of keys held afterward.
  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [COUNT_W-1:0]  cnt;
  } result_t;

  // One row of the directed table. Rows with a hand-written result carry it
  // in want; the other rows take their result from the list model.
  typedef struct packed {
    logic                    op;
    logic signed [KEY_W-1:0] k;
    logic                    typed;
    result_t                 want;
  } op_row_t;

  localparam result_t NO_RESULT = '{ST_INSERTED, 5'd0};

  // The directed part walks from an empty list, through the key extremes and
  // a delete of key zero, fills the list to capacity, hits the full case and
  // then removes from a full list.
  localparam int DIR_ROWS = 25;
  localparam op_row_t DIR_TABLE [DIR_ROWS] = '{
    '{OP_DELETE, 8'h00, 1'b1, '{ST_NOT_FOUND, 5'd0}},  // delete on an empty list
    '{OP_INSERT, 8'h80, 1'b1, '{ST_INSERTED, 5'd1}},   // most negative key
    '{OP_INSERT, 8'h7F, 1'b1, '{ST_INSERTED, 5'd2}},   // most positive key
    '{OP_INSERT, 8'h00, 1'b0, NO_RESULT},
    '{OP_INSERT, 8'hFF, 1'b0, NO_RESULT},
    '{OP_DELETE, 8'h00, 1'b0, NO_RESULT},              // key zero is a real key
    '{OP_DELETE, 8'h00, 1'b1, '{ST_NOT_FOUND, 5'd3}},
    '{OP_INSERT, 8'h7F, 1'b0, NO_RESULT},              // duplicate of the top key
    '{OP_DELETE, 8'h7F, 1'b0, NO_RESULT},
    '{OP_INSERT, 8'h55, 1'b0, NO_RESULT},
    '{OP_INSERT, 8'hAA, 1'b0, NO_RESULT},
    '{OP_INSERT, 8'h01, 1'b0, NO_RESULT},
    '{OP_INSERT, 8'h02, 1'b0, NO_RESULT},
    '{OP_INSERT, 8'hFE, 1'b0, NO_RESULT},
    '{OP_INSERT, 8'h40, 1'b0, NO_RESULT},
    '{OP_INSERT, 8'hC0, 1'b0, NO_RESULT},
    '{OP_INSERT, 8'h10, 1'b0, NO_RESULT},
    '{OP_INSERT, 8'h10, 1'b0, NO_RESULT},
    '{OP_INSERT, 8'h20, 1'b0, NO_RESULT},
    '{OP_INSERT, 8'hE0, 1'b0, NO_RESULT},
    '{OP_INSERT, 8'h08, 1'b0, NO_RESULT},
    '{OP_INSERT, 8'hF7, 1'b0, NO_RESULT},              // list now full
    '{OP_INSERT, 8'h00, 1'b1, '{ST_FULL, 5'd16}},      // dropped on a full list
    '{OP_DELETE, 8'h80, 1'b0, NO_RESULT},
    '{OP_DELETE, 8'h80, 1'b1, '{ST_NOT_FOUND, 5'd15}}
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     mode = OP_INSERT;
  logic signed [KEY_W-1:0]  key = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       count;

  // Local copy of the list: ascending keys in the low list_len cells.
  logic signed [KEY_W-1:0]  list_keys [CAPACITY];
  int                       list_len = 0;

  // Results owed by the block, oldest first.
  result_t                  expected_results [$];

  int                       mismatches = 0;
  int                       cycle_count = 0;

  // Sender pacing: beats go out in bursts; a burst ends with a gap unless
  // the current stretch has gaps turned off.
  int                       burst_left = 0;
  bit                       gaps_on = 1'b1;

  sorted_list_insert_delete i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .count     (count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Applies one operation to the local list and returns the result beat that
  // the block must produce for it. An insert lands ahead of the first key
  // that is not smaller; a delete takes the lowest equal key.
  function automatic result_t apply_list_op(logic op, logic signed [KEY_W-1:0] k);
    result_t r;
    int      pos;
    pos = 0;
    if (op == OP_INSERT) begin
      if (list_len >= CAPACITY) begin
        r.st = ST_FULL;
      end else begin
        while (pos < list_len && k > list_keys[pos]) pos++;
        for (int i = list_len; i > pos; i--) list_keys[i] = list_keys[i - 1];
        list_keys[pos] = k;
        list_len++;
        r.st = ST_INSERTED;
      end
    end else begin
      while (pos < list_len && list_keys[pos] != k) pos++;
      if (pos >= list_len) begin
        r.st = ST_NOT_FOUND;
      end else begin
        for (int i = pos; i + 1 < list_len; i++) list_keys[i] = list_keys[i + 1];
        list_len--;
        list_keys[list_len] = '0;
        r.st = ST_DELETED;
      end
    end
    r.cnt = COUNT_W'(list_len);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < PRINT_CAP) begin
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Leaves a random gap between bursts of input beats. The gap lowers valid
  // in the step where the previous beat was taken, so valid never gets two
  // assignments in one step.
  task automatic pace_sender();
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(5, 1)) @(posedge clk);
      end
      burst_left = $urandom_range(12, 1);
    end
    burst_left--;
  endtask

  // Presents one beat and holds it until the block takes it. At the edge of
  // acceptance the list model is advanced and the owed result is queued;
  // hand-written rows queue their typed result instead.
  task automatic issue_op(logic op, logic signed [KEY_W-1:0] k, logic typed,
                          result_t want);
    result_t predicted;
    pace_sender();
    in_valid <= 1'b1;
    mode     <= op;
    key      <= k;
    do @(posedge clk); while (in_stall);
    predicted = apply_list_op(op, k);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // Chooses a key for a random beat. Most deletes aim at a key that is held,
  // so the list shrinks as well as grows; a narrow band of keys around zero
  // makes duplicates common, and the rest spread over the full 8-bit range.
  function automatic logic signed [KEY_W-1:0] pick_key(logic op);
    if (op == OP_DELETE && list_len > 0 && $urandom_range(3, 0) != 0) begin
      return list_keys[$urandom_range(list_len - 1, 0)];
    end
    if ($urandom_range(1, 0) == 1) begin
      return KEY_W'($urandom_range(6, 0) - 3);
    end
    return KEY_W'($urandom_range(255, 0));
  endfunction

  // Receiver: stalls at random, with the stall rate changing every stretch
  // of cycles so that some stretches run with no stalls at all.
  int stall_pct = 0;
  int stall_phase = 0;

  always @(posedge clk) begin
    if (stall_phase == 0) begin
      case ($urandom_range(3, 0))
        0: stall_pct <= 0;
        1: stall_pct <= 30;
        2: stall_pct <= 60;
        default: stall_pct <= 85;
      endcase
      stall_phase <= $urandom_range(80, 20);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    out_stall <= ($urandom_range(99, 0) < stall_pct);
  end

  // Output checker: every accepted result beat is matched field by field
  // against the oldest owed result.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing owed, status", status, 0);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.st) report_mismatch("status", status, want.st);
        if (count !== want.cnt) report_mismatch("count", count, want.cnt);
      end
    end
  end

  initial begin
    logic op;
    int   insert_pct;
    for (int i = 0; i < CAPACITY; i++) list_keys[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    for (int r = 0; r < DIR_ROWS; r++) begin
      issue_op(DIR_TABLE[r].op, DIR_TABLE[r].k, DIR_TABLE[r].typed, DIR_TABLE[r].want);
    end

    // Random part. Every few dozen beats the mix of inserts and deletes and
    // the sender's gap behavior are chosen again, so the list swings between
    // empty and full and sits at both ends for a while.
    insert_pct = 50;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2, 0))
          0: insert_pct = 85;
          1: insert_pct = 50;
          default: insert_pct = 20;
        endcase
        gaps_on = ($urandom_range(3, 0) != 0);
      end
      op = ($urandom_range(99, 0) < insert_pct) ? OP_INSERT : OP_DELETE;
      issue_op(op, pick_key(op), 1'b0, NO_RESULT);
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
